FILE: rtl/tqs_pkg.sv
// ----------------------------------------------------------------------------
// tqs_pkg
// types and codes shared by the timer queue scheduler
// ----------------------------------------------------------------------------
package tqs_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_AFTER     = 3'd1,
        OP_AT        = 3'd2,
        OP_EVERY     = 3'd3,
        OP_CANCEL    = 3'd4,
        OP_CANCELALL = 3'd5,
        OP_STOP      = 3'd6,
        OP_START     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        K_ACK       = 3'd0,
        K_SCHEDULED = 3'd1,
        K_CANCEL    = 3'd2,
        K_FIRED     = 3'd3,
        K_ERROR     = 3'd4
    } kind_t;

    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_NOT_RUNNING = 3'd1;
    localparam logic [2:0] E_STARTED     = 3'd2;
    localparam logic [2:0] E_ZERO        = 3'd3;
    localparam logic [2:0] E_FULL        = 3'd4;
    localparam logic [2:0] E_HELD_FULL   = 3'd5;

    localparam logic [4:0] MAX_FIRED     = 5'd16;

    typedef enum logic [1:0] {
        RS_IDLE     = 2'd0,
        RS_RUNNING  = 2'd1,
        RS_STOPPED  = 2'd2,
        RS_PRESTOP  = 2'd3
    } run_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSCAN,
        S_CDROP,
        S_FSCAN,
        S_FWAIT,
        S_FPICK,
        S_FDO,
        S_OUT
    } state_t;

endpackage

FILE: rtl/timer_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// timer_queue_scheduler_core
// timer table with schedule, cancel, run control and per-tick firing
// a command other than a running tick is accepted, then held in the result
// register until delivered; a running tick first sweeps the table for cancels,
// then scans for the earliest due entry, one scan per fired item plus one,
// and each result is held in the result register until delivered; the input
// stalls until the last result is delivered
// reset is asynchronous, active low: idle, tick and ids zero, table empty
// ----------------------------------------------------------------------------
module timer_queue_scheduler_core
    import tqs_pkg::*;
#(
    parameter int TIMER_SLOTS       = 16,
    parameter int HELD_CANCEL_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [31:0] time_value,
    input  logic [31:0] cancel_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] timer_id,
    output logic        inserted,
    output logic [2:0]  error_code,
    output logic        periodic,
    output logic [4:0]  queued_count,
    output logic        last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int HW = (HELD_CANCEL_SLOTS > 1) ? $clog2(HELD_CANCEL_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    // entry memory: id, expiry, period, repeats
    logic [96:0] mem [TIMER_SLOTS];
    logic [96:0] rd_reg;
    logic        mem_we;
    logic [SW-1:0] mem_wa;
    logic [96:0] mem_wd;
    logic [SW-1:0] mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    state_t state_reg, state_next;
    run_t   run_reg, run_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] id_reg, id_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] canc_reg, canc_next;
    logic [TIMER_SLOTS-1:0] done_reg, done_next;
    logic [HELD_CANCEL_SLOTS-1:0] hv_reg, hv_next;
    logic [31:0] hid_reg [HELD_CANCEL_SLOTS];
    logic        hwe;
    logic [HW-1:0] hwa;
    logic [31:0] hwd;
    logic [SW:0] idx_reg, idx_next;
    logic [4:0]  nfire_reg, nfire_next;
    logic        best_ok_reg, best_ok_next;
    logic [SW-1:0] best_reg, best_next;
    logic [31:0] best_exp_reg, best_exp_next;
    logic [31:0] best_id_reg, best_id_next;
    logic [SW-1:0] ridx_reg, ridx_next;

    logic        ov_reg, ov_next;
    logic [2:0]  k_reg, k_next;
    logic [31:0] tid_reg, tid_next;
    logic        ins_reg, ins_next;
    logic [2:0]  err_reg, err_next;
    logic        per_reg, per_next;
    logic        last_reg, last_next;

    logic [CW-1:0] live;
    always_comb
    begin
        live = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            live = live + CW'(valid_reg[i]);
        end
    end

    // held store match
    logic [HELD_CANCEL_SLOTS-1:0] hmatch;
    logic [31:0] hkey;
    logic        hhit;
    logic [HW-1:0] hhit_idx, hfree_idx;
    logic        hfree;
    always_comb
    begin
        hhit = 1'b0;
        hhit_idx = '0;
        hfree = 1'b0;
        hfree_idx = '0;
        for (int i = HELD_CANCEL_SLOTS - 1; i >= 0; i--)
        begin
            hmatch[i] = hv_reg[i] && (hid_reg[i] == hkey);
            if (hmatch[i])
            begin
                hhit = 1'b1;
                hhit_idx = HW'(i);
            end
            if (!hv_reg[i])
            begin
                hfree = 1'b1;
                hfree_idx = HW'(i);
            end
        end
    end

    logic sfree;
    logic [SW-1:0] sfree_idx;
    always_comb
    begin
        sfree = 1'b0;
        sfree_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                sfree = 1'b1;
                sfree_idx = SW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            hid_reg[hwa] <= hwd;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    wire accept = in_valid && !in_stall;
    wire [SW-1:0] idx = idx_reg[SW-1:0];
    wire scan_end = (idx_reg == (SW+1)'(TIMER_SLOTS));
    wire fire_ok = best_ok_reg && (nfire_reg != MAX_FIRED);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && op_t'(operation) == OP_TICK
                         && run_reg == RS_RUNNING) state_next = S_CSCAN;
                     else if (accept) state_next = S_IDLE;
            S_CSCAN: if (scan_end) state_next = S_FSCAN;
                     else state_next = S_CDROP;
            S_CDROP: state_next = S_CSCAN;
            S_FSCAN: state_next = S_FWAIT;
            S_FWAIT: state_next = scan_end ? S_FPICK : S_FWAIT;
            S_FPICK: state_next = S_FDO;
            S_FDO:   state_next = S_OUT;
            S_OUT:   if (!ov_reg) state_next = last_reg ? S_IDLE : S_FSCAN;
            default: state_next = S_IDLE;
        endcase
    end

    logic [31:0] r_id, r_exp, r_per;
    logic        r_rep;
    assign r_id  = rd_reg[96:65];
    assign r_exp = rd_reg[64:33];
    assign r_per = rd_reg[32:1];
    assign r_rep = rd_reg[0];

    logic [31:0] sched_exp;
    logic        cand;

    always_comb
    begin
        run_next = run_reg; tick_next = tick_reg; id_next = id_reg;
        valid_next = valid_reg; canc_next = canc_reg; done_next = done_reg;
        hv_next = hv_reg; hwe = 1'b0; hwa = hfree_idx; hwd = cancel_id;
        idx_next = idx_reg; nfire_next = nfire_reg;
        best_ok_next = best_ok_reg; best_next = best_reg;
        best_exp_next = best_exp_reg; best_id_next = best_id_reg;
        ridx_next = ridx_reg;
        mem_we = 1'b0; mem_wa = sfree_idx; mem_wd = '0; mem_ra = idx;
        ov_next = ov_reg && out_stall;
        k_next = k_reg; tid_next = tid_reg; ins_next = ins_reg; err_next = err_reg;
        per_next = per_reg; last_next = last_reg;
        hkey = cancel_id;
        sched_exp = (op_t'(operation) == OP_AT) ? time_value : tick_reg + time_value;
        cand = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ov_next = 1'b1; k_next = K_ACK; tid_next = '0; ins_next = 1'b0;
                    err_next = E_NONE; per_next = 1'b0; last_next = 1'b1;
                    unique case (op_t'(operation))
                        OP_TICK:
                        begin
                            tick_next = tick_reg + 32'd1;
                            if (run_reg == RS_RUNNING)
                            begin
                                ov_next = 1'b0; idx_next = '0; nfire_next = '0;
                                done_next = '0;
                            end
                        end
                        OP_AFTER, OP_AT, OP_EVERY:
                        begin
                            k_next = K_ERROR;
                            if (run_reg != RS_RUNNING) err_next = E_NOT_RUNNING;
                            else if (op_t'(operation) == OP_EVERY && time_value == '0)
                                err_next = E_ZERO;
                            else if (!sfree) err_next = E_FULL;
                            else
                            begin
                                id_next = id_reg + 32'd1;
                                k_next = K_SCHEDULED; tid_next = id_reg + 32'd1;
                                mem_we = 1'b1;
                                mem_wd = {id_reg + 32'd1, sched_exp,
                                    (op_t'(operation) == OP_EVERY) ? time_value : 32'd0,
                                    op_t'(operation) == OP_EVERY};
                                valid_next[sfree_idx] = 1'b1;
                                canc_next[sfree_idx] = 1'b0;
                            end
                        end
                        OP_CANCEL:
                        begin
                            k_next = K_CANCEL; tid_next = cancel_id;
                            if (hhit) ins_next = 1'b0;
                            else if (hfree)
                            begin
                                ins_next = 1'b1; hwe = 1'b1; hv_next[hfree_idx] = 1'b1;
                            end
                            else
                            begin
                                k_next = K_ERROR; tid_next = '0; err_next = E_HELD_FULL;
                            end
                        end
                        OP_CANCELALL:
                        begin
                            canc_next = canc_reg | valid_reg; hv_next = '0;
                        end
                        OP_STOP:
                        begin
                            if (run_reg == RS_IDLE || run_reg == RS_RUNNING)
                            begin
                                run_next = (run_reg == RS_IDLE) ? RS_PRESTOP : RS_STOPPED;
                                valid_next = '0; hv_next = '0;
                            end
                        end
                        default:
                        begin
                            if (run_reg == RS_IDLE || run_reg == RS_PRESTOP)
                                run_next = RS_RUNNING;
                            else
                            begin
                                k_next = K_ERROR; err_next = E_STARTED;
                            end
                        end
                    endcase
                end
            end
            S_CSCAN:
            begin
                mem_ra = idx;
                ridx_next = idx;
            end
            S_CDROP:
            begin
                hkey = r_id;
                if (valid_reg[ridx_reg] && (canc_reg[ridx_reg] || hhit))
                begin
                    valid_next[ridx_reg] = 1'b0;
                    if (hhit) hv_next[hhit_idx] = 1'b0;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_FSCAN:
            begin
                idx_next = '0; best_ok_next = 1'b0; mem_ra = '0;
            end
            S_FWAIT:
            begin
                // pipelined scan: read slot idx+1, evaluate slot idx
                mem_ra = SW'(idx_reg + 1'b1);
                cand = !scan_end && valid_reg[idx] && !done_reg[idx]
                    && (r_exp <= tick_reg);
                if (cand && (!best_ok_reg || r_exp < best_exp_reg ||
                    (r_exp == best_exp_reg && r_id < best_id_reg)))
                begin
                    best_ok_next = 1'b1; best_next = idx;
                    best_exp_next = r_exp; best_id_next = r_id;
                end
                idx_next = idx_reg + 1'b1;
            end
            S_FPICK:
            begin
                mem_ra = best_reg;
            end
            S_FDO:
            begin
                if (fire_ok)
                begin
                    done_next[best_reg] = 1'b1;
                    if (r_rep)
                    begin
                        mem_we = 1'b1; mem_wa = best_reg;
                        mem_wd = {r_id, tick_reg + r_per, r_per, 1'b1};
                    end
                    else valid_next[best_reg] = 1'b0;
                    nfire_next = nfire_reg + 5'd1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    logic [CW-1:0] live_after;
    always_comb
    begin
        live_after = live;
        if (state_reg == S_FDO && fire_ok && !r_rep) live_after = live - CW'(1);
        if (state_reg == S_IDLE && accept) live_after = CW'($countones(valid_next));
    end

    // entry counts saturate at the width of queued_count
    logic [4:0] q_sat, live_sat;
    assign q_sat    = (live_after > CW'(31)) ? 5'd31 : 5'(live_after);
    assign live_sat = (live > CW'(31)) ? 5'd31 : 5'(live);

    logic [4:0] q_reg, q_next;
    always_comb
    begin
        q_next = q_reg;
        if (state_reg == S_IDLE) q_next = q_sat;
    end

    // a fired item is held back until the next scan decides whether another
    // one follows, so that its last flag is known
    logic        fo_v_reg, fo_v_next;
    logic [31:0] fo_id_reg, fo_id_next;
    logic        fo_p_reg, fo_p_next;
    logic [4:0]  fo_q_reg, fo_q_next;
    always_comb
    begin
        fo_v_next = fo_v_reg; fo_id_next = fo_id_reg; fo_p_next = fo_p_reg;
        fo_q_next = fo_q_reg;
        if (state_reg == S_FDO)
        begin
            if (fire_ok)
            begin
                fo_v_next = 1'b1; fo_id_next = r_id; fo_p_next = r_rep;
                fo_q_next = q_sat;
            end
            else fo_v_next = 1'b0;
        end
    end

    logic        busy_out;
    assign busy_out = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; run_reg <= RS_IDLE; tick_reg <= '0; id_reg <= '0;
            valid_reg <= '0; hv_reg <= '0; ov_reg <= 1'b0; fo_v_reg <= 1'b0;
            idx_reg <= '0; nfire_reg <= '0; done_reg <= '0; canc_reg <= '0;
            best_ok_reg <= 1'b0;
            k_reg <= K_ACK; tid_reg <= '0; ins_reg <= 1'b0; err_reg <= E_NONE;
            per_reg <= 1'b0; last_reg <= 1'b0; q_reg <= '0;
        end
        else
        begin
            run_reg <= run_next; tick_reg <= tick_next; id_reg <= id_next;
            valid_reg <= valid_next; hv_reg <= hv_next; done_reg <= done_next;
            canc_reg <= canc_next; idx_reg <= idx_next;
            best_ok_reg <= best_ok_next;
            fo_v_reg <= fo_v_next;
            nfire_reg <= nfire_next;
            if (state_reg == S_FDO)
            begin
                // reached limit or nothing more: finish
                if (!fire_ok)
                begin
                    state_reg <= (fo_v_reg || nfire_reg == '0) ? S_OUT : S_IDLE;
                    ov_reg <= fo_v_reg || nfire_reg == '0;
                    last_reg <= 1'b1;
                    if (fo_v_reg)
                    begin
                        k_reg <= K_FIRED; tid_reg <= fo_id_reg; per_reg <= fo_p_reg;
                        q_reg <= fo_q_reg;
                    end
                    else
                    begin
                        k_reg <= K_ACK; tid_reg <= '0; per_reg <= 1'b0;
                        q_reg <= live_sat;
                    end
                    ins_reg <= 1'b0; err_reg <= E_NONE;
                end
                else
                begin
                    state_reg <= fo_v_reg ? S_OUT : S_FSCAN;
                    ov_reg <= fo_v_reg; last_reg <= 1'b0;
                    k_reg <= K_FIRED; tid_reg <= fo_id_reg; per_reg <= fo_p_reg;
                    q_reg <= fo_q_reg; ins_reg <= 1'b0; err_reg <= E_NONE;
                end
            end
            else
            begin
                state_reg <= state_next; ov_reg <= ov_next;
                k_reg <= k_next; tid_reg <= tid_next; ins_reg <= ins_next;
                err_reg <= err_next; per_reg <= per_next; last_reg <= last_next;
                q_reg <= q_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next; best_exp_reg <= best_exp_next;
        best_id_reg <= best_id_next; ridx_reg <= ridx_next;
        fo_id_reg <= fo_id_next; fo_p_reg <= fo_p_next; fo_q_reg <= fo_q_next;
    end

    assign out_valid    = busy_out;
    assign kind         = k_reg;
    assign timer_id     = tid_reg;
    assign inserted     = ins_reg;
    assign error_code   = err_reg;
    assign periodic     = per_reg;
    assign queued_count = q_reg;
    assign last         = last_reg;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer queue scheduler testbench
// drives commands through the valid/stall input with random gaps, predicts
// every result from a local model of the timer table and held cancels, and
// compares each delivered result field by field in order
// ----------------------------------------------------------------------------
module testbench;
    import tqs_pkg::*;

    localparam int SLOTS = 16;
    localparam int HELD  = 8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] timer_id;
        logic        inserted;
        logic [2:0]  error_code;
        logic        periodic;
        logic [4:0]  queued_count;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = 3'd0;
    logic [31:0] time_value = 32'd0;
    logic [31:0] cancel_id = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic        inserted;
    logic [2:0]  error_code;
    logic        periodic;
    logic [4:0]  queued_count;
    logic        last;

    timer_queue_scheduler_core dut (.*);

    always #4 clk = ~clk;

    // model state
    run_t        m_run;
    logic [31:0] m_now;
    logic [31:0] m_last_id;
    logic        m_valid [SLOTS];
    logic [31:0] m_id [SLOTS];
    logic [31:0] m_exp [SLOTS];
    logic [31:0] m_per [SLOTS];
    logic        m_rep [SLOTS];
    logic        m_canc [SLOTS];
    logic        m_hv [HELD];
    logic [31:0] m_hid [HELD];

    result_t expected_results [$];
    int errors = 0;
    int hold_cycles = 0;
    bit sender_gaps = 1'b1;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        end
    endtask

    function automatic logic [4:0] live_count();
        int c;
        c = 0;
        for (int i = 0; i < SLOTS; i++) if (m_valid[i]) c++;
        return 5'(c);
    endfunction

    function automatic int held_index(input logic [31:0] id);
        for (int i = 0; i < HELD; i++) if (m_hv[i] && m_hid[i] == id) return i;
        return -1;
    endfunction

    task automatic push_result(input kind_t k, input logic [31:0] id, input logic ins,
                               input logic [2:0] err, input logic per);
        result_t r;
        begin
            r.kind = k; r.timer_id = id; r.inserted = ins; r.error_code = err;
            r.periodic = per; r.queued_count = live_count(); r.last = 1'b0;
            expected_results.push_back(r);
        end
    endtask

    task automatic schedule_timer(input logic [31:0] ex, input logic [31:0] per, input bit rep);
        int slot;
        begin
            slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) if (!m_valid[i]) slot = i;
            if (m_run != RS_RUNNING) push_result(K_ERROR, 0, 0, E_NOT_RUNNING, 0);
            else if (rep && per == 0) push_result(K_ERROR, 0, 0, E_ZERO, 0);
            else if (slot < 0) push_result(K_ERROR, 0, 0, E_FULL, 0);
            else
            begin
                m_last_id = m_last_id + 1;
                m_valid[slot] = 1; m_id[slot] = m_last_id; m_exp[slot] = ex;
                m_per[slot] = rep ? per : 0; m_rep[slot] = rep; m_canc[slot] = 0;
                push_result(K_SCHEDULED, m_last_id, 0, E_NONE, 0);
            end
        end
    endtask

    task automatic advance_tick();
        bit done [SLOTS];
        int n, best, h;
        begin
            m_now = m_now + 1;
            n = 0;
            if (m_run != RS_RUNNING) push_result(K_ACK, 0, 0, E_NONE, 0);
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    done[i] = 0;
                    if (m_valid[i])
                    begin
                        h = held_index(m_id[i]);
                        if (m_canc[i] || h >= 0)
                        begin
                            m_valid[i] = 0;
                            if (h >= 0) m_hv[h] = 0;
                        end
                    end
                end
                while (n < 16)
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!m_valid[i] || done[i] || m_exp[i] > m_now) continue;
                        if (best < 0 || m_exp[i] < m_exp[best] ||
                            (m_exp[i] == m_exp[best] && m_id[i] < m_id[best]))
                            best = i;
                    end
                    if (best < 0) break;
                    done[best] = 1;
                    if (m_rep[best]) m_exp[best] = m_now + m_per[best];
                    else m_valid[best] = 0;
                    push_result(K_FIRED, m_id[best], 0, E_NONE, m_rep[best]);
                    n++;
                end
                if (n == 0) push_result(K_ACK, 0, 0, E_NONE, 0);
            end
        end
    endtask

    task automatic predict_item(input op_t op, input logic [31:0] tv, input logic [31:0] cid);
        int h;
        begin
            case (op)
                OP_TICK:   advance_tick();
                OP_AFTER:  schedule_timer(m_now + tv, 0, 0);
                OP_AT:     schedule_timer(tv, 0, 0);
                OP_EVERY:  schedule_timer(m_now + tv, tv, 1);
                OP_CANCEL:
                begin
                    if (held_index(cid) >= 0) push_result(K_CANCEL, cid, 0, E_NONE, 0);
                    else
                    begin
                        h = -1;
                        for (int i = HELD - 1; i >= 0; i--) if (!m_hv[i]) h = i;
                        if (h < 0) push_result(K_ERROR, 0, 0, E_HELD_FULL, 0);
                        else
                        begin
                            m_hv[h] = 1; m_hid[h] = cid;
                            push_result(K_CANCEL, cid, 1, E_NONE, 0);
                        end
                    end
                end
                OP_CANCELALL:
                begin
                    for (int i = 0; i < SLOTS; i++) if (m_valid[i]) m_canc[i] = 1;
                    for (int i = 0; i < HELD; i++) m_hv[i] = 0;
                    push_result(K_ACK, 0, 0, E_NONE, 0);
                end
                OP_STOP:
                begin
                    if (m_run == RS_IDLE || m_run == RS_RUNNING)
                    begin
                        m_run = (m_run == RS_IDLE) ? RS_PRESTOP : RS_STOPPED;
                        for (int i = 0; i < SLOTS; i++) m_valid[i] = 0;
                        for (int i = 0; i < HELD; i++) m_hv[i] = 0;
                    end
                    push_result(K_ACK, 0, 0, E_NONE, 0);
                end
                default:
                begin
                    if (m_run == RS_IDLE || m_run == RS_PRESTOP)
                    begin
                        m_run = RS_RUNNING;
                        push_result(K_ACK, 0, 0, E_NONE, 0);
                    end
                    else push_result(K_ERROR, 0, 0, E_STARTED, 0);
                end
            endcase
            expected_results[$].last = 1'b1;
        end
    endtask

    task automatic send_item(input op_t op, input logic [31:0] tv, input logic [31:0] cid);
        int gap;
        begin
            gap = sender_gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
            repeat (gap) @(negedge clk);
            in_valid = 1'b1; operation = op; time_value = tv; cancel_id = cid;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            predict_item(op, tv, cid);
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            while (expected_results.size() != 0) @(negedge clk);
            repeat (100) @(negedge clk);
        end
    endtask

    // receiver stall process
    initial
    begin
        int w;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
            begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                out_stall = (w != 0);
                repeat (w) @(negedge clk);
                out_stall = 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0) report("unexpected result", kind, 0);
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind) report("kind", kind, e.kind);
                if (timer_id !== e.timer_id) report("timer_id", timer_id, e.timer_id);
                if (inserted !== e.inserted) report("inserted", inserted, e.inserted);
                if (error_code !== e.error_code) report("error_code", error_code, e.error_code);
                if (periodic !== e.periodic) report("periodic", periodic, e.periodic);
                if (queued_count !== e.queued_count)
                    report("queued_count", queued_count, e.queued_count);
                if (last !== e.last) report("last", last, e.last);
            end
        end
    end

    task automatic test_run_control();
        begin
            send_item(OP_TICK, 0, 0);
            send_item(OP_AFTER, 5, 0);
            send_item(OP_STOP, 0, 0);
            send_item(OP_STOP, 0, 0);
            send_item(OP_START, 0, 0);
            send_item(OP_START, 0, 0);
        end
    endtask

    task automatic test_directed();
        begin
            send_item(OP_EVERY, 0, 0);
            send_item(OP_AFTER, 32'hFFFF_FFFF, 0);
            send_item(OP_AT, 32'd0, 0);
            send_item(OP_AT, 32'd3, 0);
            send_item(OP_EVERY, 2, 0);
            send_item(OP_CANCEL, 3, 0);
            send_item(OP_CANCEL, 3, 0);
            send_item(OP_CANCEL, 32'd9, 0);
            send_item(OP_CANCEL, 0, 32'hFFFF_FFFF);
            send_item(OP_CANCEL, 0, 32'd9);
            send_item(OP_TICK, 0, 0);
            send_item(OP_TICK, 0, 0);
            send_item(OP_AFTER, 1, 32'd9);
            send_item(OP_CANCELALL, 0, 0);
            send_item(OP_TICK, 0, 0);
            for (int i = 0; i < 8; i++) send_item(OP_CANCEL, 0, 32'h100 + i);
            send_item(OP_CANCEL, 0, 32'h200);
            send_item(OP_CANCELALL, 0, 0);
        end
    endtask

    task automatic test_full_table();
        begin
            for (int i = 0; i < 17; i++) send_item(OP_AT, $urandom_range(0, 3), 0);
            send_item(OP_TICK, 0, 0);
            send_item(OP_TICK, 0, 0);
            send_item(OP_STOP, 0, 0);
            send_item(OP_START, 0, 0);
        end
    endtask

    task automatic test_backpressure();
        begin
            wait_drained();
            @(negedge clk);
            hold_cycles = 400;
            for (int i = 0; i < 12; i++) send_item(OP_AFTER, $urandom_range(0, 2), 0);
            send_item(OP_TICK, 0, 0);
            send_item(OP_TICK, 0, 0);
            send_item(OP_TICK, 0, 0);
            wait_drained();
        end
    endtask

    task automatic test_random();
        int r;
        logic [31:0] tv, cid;
        begin
            for (int n = 0; n < 380; n++)
            begin
                if (n == 190) wait_drained();
                sender_gaps = ((n / 40) % 3) != 2;
                r = $urandom_range(0, 99);
                tv = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
                cid = ($urandom_range(0, 9) == 0) ? $urandom() :
                      m_last_id - $urandom_range(0, 4) + 2;
                if (r < 35) send_item(OP_TICK, $urandom(), $urandom());
                else if (r < 50) send_item(OP_AFTER, tv, $urandom());
                else if (r < 58) send_item(OP_AT, m_now + tv, $urandom());
                else if (r < 68) send_item(OP_EVERY, tv, $urandom());
                else if (r < 84) send_item(OP_CANCEL, $urandom(), cid);
                else if (r < 88) send_item(OP_CANCELALL, $urandom(), $urandom());
                else if (r < 93) send_item(OP_STOP, $urandom(), $urandom());
                else send_item(OP_START, $urandom(), $urandom());
            end
            sender_gaps = 1'b1;
        end
    endtask

    initial
    begin
        m_run = RS_IDLE; m_now = 0; m_last_id = 0;
        for (int i = 0; i < SLOTS; i++) m_valid[i] = 0;
        for (int i = 0; i < HELD; i++) m_hv[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_run_control();
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        wait_drained();
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
rtl/tqs_pkg.sv
rtl/timer_queue_scheduler_core.sv
tb/sv/testbench.sv
